FILE: rtl/core/rv32x_pkg.sv
// package for the rv32i integer execute unit: payload types, opcodes, sizes
// depends on nothing
package rv32x_pkg;

  localparam int unsigned DataBytes = 4096;
  localparam int unsigned MemAw = $clog2(DataBytes);
  localparam int unsigned WordAw = MemAw - 2;
  localparam int unsigned Words = DataBytes / 4;

  localparam logic [4:0] OP_ADDI  = 5'd0;
  localparam logic [4:0] OP_SLTI  = 5'd1;
  localparam logic [4:0] OP_SLTIU = 5'd2;
  localparam logic [4:0] OP_ANDI  = 5'd3;
  localparam logic [4:0] OP_ORI   = 5'd4;
  localparam logic [4:0] OP_XORI  = 5'd5;
  localparam logic [4:0] OP_SLLI  = 5'd6;
  localparam logic [4:0] OP_SRLI  = 5'd7;
  localparam logic [4:0] OP_SRAI  = 5'd8;
  localparam logic [4:0] OP_ADD   = 5'd9;
  localparam logic [4:0] OP_SUB   = 5'd10;
  localparam logic [4:0] OP_SLT   = 5'd11;
  localparam logic [4:0] OP_SLTU  = 5'd12;
  localparam logic [4:0] OP_AND   = 5'd13;
  localparam logic [4:0] OP_OR    = 5'd14;
  localparam logic [4:0] OP_XOR   = 5'd15;
  localparam logic [4:0] OP_SLL   = 5'd16;
  localparam logic [4:0] OP_SRL   = 5'd17;
  localparam logic [4:0] OP_SRA   = 5'd18;
  localparam logic [4:0] OP_LB    = 5'd19;
  localparam logic [4:0] OP_LBU   = 5'd20;
  localparam logic [4:0] OP_LH    = 5'd21;
  localparam logic [4:0] OP_LHU   = 5'd22;
  localparam logic [4:0] OP_LW    = 5'd23;
  localparam logic [4:0] OP_SB    = 5'd24;
  localparam logic [4:0] OP_SH    = 5'd25;
  localparam logic [4:0] OP_SW    = 5'd26;
  localparam logic [4:0] OP_LUI   = 5'd27;
  localparam logic [4:0] OP_AUIPC = 5'd28;

  typedef struct packed {
    logic [4:0]  action;
    logic [4:0]  src_one;
    logic [4:0]  src_two;
    logic [4:0]  dest;
    logic signed [31:0] immediate;
    logic [31:0] pc_value;
  } in_item_t;

  typedef struct packed {
    logic        wrote_reg;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic [31:0] mem_address;
    logic        is_store;
    logic        addr_out_of_range;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;  // capture input, read register file
    logic exec;       // compute, read or write memory word
    logic finish;     // write back, build result
    logic clr;        // memory clear pass step
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic two_words;  // access spans two memory words
  } sts_t;

endpackage

FILE: rtl/core/rv32x_datapath.sv
// datapath: register file, alu, word-organized data memory, result register
// depends on rv32x_pkg
module rv32x_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rv32x_pkg::cmd_t      cmd_i,
  input  logic                 second_i,
  input  rv32x_pkg::in_item_t  item_i,
  output rv32x_pkg::sts_t      sts_o,
  output rv32x_pkg::out_item_t res_o
);
  import rv32x_pkg::*;

  logic [31:0] rf_q [32];
  logic [31:0] mem_q [Words];
  in_item_t    it_q;
  logic [31:0] a_q, b_q;
  logic [WordAw-1:0] clr_cnt_q;
  logic [31:0] rd_word_q, lo_word_q;
  logic [31:0] alu_q;
  logic [31:0] addr_q;
  out_item_t   res_q;
  out_item_t   res_d;

  // operand decode
  logic [31:0] imm_u, opb, sum_ab, sub_ab, alu_d, upper, ea;
  logic [4:0]  sh;
  logic        is_imm_op, lt_s, lt_u;
  assign is_imm_op = (it_q.action <= OP_SRAI);
  assign opb = is_imm_op ? it_q.immediate : b_q;
  assign sh = opb[4:0];
  assign sum_ab = a_q + opb;
  assign sub_ab = a_q - b_q;
  assign ea = a_q + it_q.immediate;
  assign lt_s = $signed(a_q) < $signed(opb);
  assign lt_u = a_q < opb;
  assign upper = {it_q.immediate[19:0], 12'h000};

  always_comb begin
    case (it_q.action)
      OP_ADDI, OP_ADD:        alu_d = sum_ab;
      OP_SUB:                 alu_d = sub_ab;
      OP_SLTI, OP_SLT:        alu_d = {31'd0, lt_s};
      OP_SLTIU, OP_SLTU:      alu_d = {31'd0, lt_u};
      OP_ANDI, OP_AND:        alu_d = a_q & opb;
      OP_ORI, OP_OR:          alu_d = a_q | opb;
      OP_XORI, OP_XOR:        alu_d = a_q ^ opb;
      OP_SLLI, OP_SLL:        alu_d = a_q << sh;
      OP_SRLI, OP_SRL:        alu_d = a_q >> sh;
      OP_SRAI, OP_SRA:        alu_d = $unsigned($signed(a_q) >>> sh);
      OP_LUI:                 alu_d = upper;
      OP_AUIPC:               alu_d = it_q.pc_value + upper;
      default:                alu_d = '0;
    endcase
  end

  // memory access decode
  logic is_mem, is_st, is_load;
  logic [2:0] size;
  assign is_mem = (it_q.action >= OP_LB) && (it_q.action <= OP_SW);
  assign is_st = (it_q.action >= OP_SB) && (it_q.action <= OP_SW);
  assign is_load = is_mem && !is_st;
  always_comb begin
    case (it_q.action)
      OP_LB, OP_LBU, OP_SB: size = 3'd1;
      OP_LH, OP_LHU, OP_SH: size = 3'd2;
      default:              size = 3'd4;
    endcase
  end

  logic [WordAw-1:0] w0, wsel;
  logic [1:0]  boff;
  logic [32:0] last_byte;
  assign w0 = addr_q[MemAw-1:2];
  assign boff = addr_q[1:0];
  assign wsel = w0 + {{(WordAw-1){1'b0}}, second_i};
  assign last_byte = {1'b0, addr_q} + {30'd0, size} - 33'd1;
  assign sts_o.two_words = is_mem && (({1'b0, boff} + size) > 3'd4);
  assign sts_o.clr_done = (clr_cnt_q == WordAw'(Words - 1));

  // store lanes: 8 byte window across two words
  logic [63:0] st_data;
  logic [7:0]  st_mask;
  logic [3:0]  sz_mask;
  assign sz_mask = (size == 3'd1) ? 4'b0001 : (size == 3'd2) ? 4'b0011 : 4'b1111;
  assign st_data = {32'd0, b_q} << {boff, 3'b000};
  assign st_mask = {4'd0, sz_mask} << boff;

  logic [31:0] wdata;
  logic [3:0]  wmask;
  assign wdata = second_i ? st_data[63:32] : st_data[31:0];
  assign wmask = second_i ? st_mask[7:4] : st_mask[3:0];

  // memory: clear pass, byte-masked write, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.exec && is_st) begin
      for (int k = 0; k < 4; k++) begin
        if (wmask[k]) mem_q[wsel][8*k +: 8] <= wdata[8*k +: 8];
      end
    end
    rd_word_q <= mem_q[wsel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // register file with x0 hardwired to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 32; r++) rf_q[r] <= '0;
    end else if (cmd_i.finish && res_d.wrote_reg) begin
      rf_q[it_q.dest] <= res_d.write_value;
    end
  end

  // item capture, alu result, low read word and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      it_q <= item_i;
      a_q <= (item_i.src_one == 5'd0) ? 32'd0 : rf_q[item_i.src_one];
      b_q <= (item_i.src_two == 5'd0) ? 32'd0 : rf_q[item_i.src_two];
    end
    if (cmd_i.exec && !second_i) begin
      alu_q <= alu_d;
    end
    if (cmd_i.exec && second_i) lo_word_q <= rd_word_q;
    if (cmd_i.finish) res_q <= res_d;
  end

  // effective address is registered during the address state, ahead of memory access
  logic addr_phase_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) addr_phase_q <= 1'b1;
    else addr_phase_q <= 1'b0;
    if (addr_phase_q) addr_q <= ea;
  end

  // load extract from the one or two words read
  logic [63:0] win;
  logic [31:0] ld_raw, ld_val;
  assign win = sts_o.two_words ? {rd_word_q, lo_word_q} : {32'd0, rd_word_q};
  assign ld_raw = 32'(win >> {boff, 3'b000});
  always_comb begin
    case (it_q.action)
      OP_LB:   ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      OP_LBU:  ld_val = {24'd0, ld_raw[7:0]};
      OP_LH:   ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      OP_LHU:  ld_val = {16'd0, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
  end

  logic writes;
  logic [31:0] val;
  assign writes = (it_q.dest != 5'd0) && !is_st && (it_q.action <= OP_AUIPC);
  assign val = is_load ? ld_val : alu_q;
  always_comb begin
    res_d.wrote_reg = writes;
    res_d.dest_reg = writes ? it_q.dest : 5'd0;
    res_d.write_value = writes ? val : 32'd0;
    res_d.mem_address = is_mem ? addr_q : 32'd0;
    res_d.is_store = is_st;
    res_d.addr_out_of_range = is_mem && (last_byte >= 33'(DataBytes));
  end
  assign res_o = res_q;

endmodule

FILE: rtl/core/rv32x_ctrl.sv
// controller: clear pass after reset, item sequencing, output handshake
// depends on rv32x_pkg
module rv32x_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rv32x_pkg::sts_t sts_i,
  output rv32x_pkg::cmd_t cmd_o,
  output logic            second_o
);
  import rv32x_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ADDR, S_RD0, S_RD1, S_WAIT, S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  // accept a new item in idle only once the previous result is gone or taken in this cycle
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    second_o = 1'b0;
    cmd_o.clr = (state_q == S_CLEAR);
    cmd_o.load_item = accept;
    case (state_q)
      S_RD0:   cmd_o.exec = 1'b1;
      S_RD1:   begin cmd_o.exec = 1'b1; second_o = 1'b1; end
      S_WAIT:  second_o = sts_i.two_words;
      S_FIN:   begin cmd_o.finish = 1'b1; second_o = sts_i.two_words; end
      default: ;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FIN) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: if (sts_i.clr_done) state_q <= S_IDLE;
        S_IDLE:  if (accept) state_q <= S_ADDR;
        S_ADDR:  state_q <= S_RD0;
        S_RD0:   state_q <= sts_i.two_words ? S_RD1 : S_WAIT;
        S_RD1:   state_q <= S_WAIT;
        S_WAIT:  state_q <= S_FIN;
        S_FIN:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o) else $error("ready during clear");
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> out_valid_q) else $error("result not raised");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_item, cmd_o.exec, cmd_o.finish, cmd_o.clr}))
    else $error("overlapping commands");
`endif

endmodule

FILE: rtl/core/rv32i_integer_execute_unit.sv
// rv32i integer execute unit: one decoded instruction per transaction
// after accept: address, read, second read (when an access spans two memory words), wait and
// finish states, then result valid; no new item is taken until the controller is back in idle
// after reset a clearing pass zeroes all DataBytes/4 (1024) data memory words, no item taken
// the register file clears at once through reset
module rv32i_integer_execute_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rv32x_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rv32x_pkg::out_item_t out_data_o
);
  import rv32x_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic second;

  rv32x_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd), .second_o(second)
  );

  rv32x_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .second_i(second), .item_i(in_data_i),
    .sts_o(sts), .res_o(out_data_o)
  );

endmodule

FILE: dv/rv32i_integer_execute_unit_test.sv
// testbench for the rv32i integer execute unit: directed and random instructions
// checked against an in-bench predictor of registers and data memory; depends on rv32x_pkg and the unit
`timescale 1ns / 1ps

module rv32i_integer_execute_unit_test;
  import rv32x_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  in_item_t in_data_i = '0;
  logic in_ready_o, out_valid_o;
  out_item_t out_data_o;

  rv32i_integer_execute_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] regs [32];
  logic [7:0]  mem [DataBytes];
  in_item_t    pending_insns [$];
  out_item_t   expected_results [$];
  int          errors = 0;
  int          idle_cycles = 0;
  logic        quiet_phase = 1'b0;
  logic        stim_done = 1'b0;

  function automatic logic [31:0] rd_reg(logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : regs[idx];
  endfunction

  // execute one instruction on the predictor state
  function automatic out_item_t execute_insn(in_item_t it);
    out_item_t   r;
    logic [31:0] a, b, imm, res, addr;
    logic [32:0] last;
    int unsigned size;
    logic        writes, is_mem;
    r = '0;
    a = rd_reg(it.src_one);
    b = rd_reg(it.src_two);
    imm = it.immediate;
    res = '0;
    addr = '0;
    size = 0;
    writes = 1'b1;
    is_mem = 1'b0;
    case (it.action)
      OP_ADDI:  res = a + imm;
      OP_SLTI:  res = {31'd0, $signed(a) < $signed(imm)};
      OP_SLTIU: res = {31'd0, a < imm};
      OP_ANDI:  res = a & imm;
      OP_ORI:   res = a | imm;
      OP_XORI:  res = a ^ imm;
      OP_SLLI:  res = a << imm[4:0];
      OP_SRLI:  res = a >> imm[4:0];
      OP_SRAI:  res = $signed(a) >>> imm[4:0];
      OP_ADD:   res = a + b;
      OP_SUB:   res = a - b;
      OP_SLT:   res = {31'd0, $signed(a) < $signed(b)};
      OP_SLTU:  res = {31'd0, a < b};
      OP_AND:   res = a & b;
      OP_OR:    res = a | b;
      OP_XOR:   res = a ^ b;
      OP_SLL:   res = a << b[4:0];
      OP_SRL:   res = a >> b[4:0];
      OP_SRA:   res = $signed(a) >>> b[4:0];
      OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW: begin
        is_mem = 1'b1;
        addr = a + imm;
        size = (it.action inside {OP_LB, OP_LBU, OP_SB}) ? 1 :
               (it.action inside {OP_LH, OP_LHU, OP_SH}) ? 2 : 4;
        last = {1'b0, addr} + size - 1;
        r.addr_out_of_range = (last >= DataBytes);
        if (it.action inside {OP_SB, OP_SH, OP_SW}) begin
          writes = 1'b0;
          r.is_store = 1'b1;
          for (int k = 0; k < size; k++)
            mem[(addr + k) % DataBytes] = b[8*k +: 8];
        end else begin
          for (int k = 0; k < size; k++)
            res[8*k +: 8] = mem[(addr + k) % DataBytes];
          if (it.action == OP_LB && res[7]) res[31:8] = '1;
          if (it.action == OP_LH && res[15]) res[31:16] = '1;
        end
      end
      OP_LUI:   res = {imm[19:0], 12'd0};
      OP_AUIPC: res = it.pc_value + {imm[19:0], 12'd0};
      default:  writes = 1'b0;
    endcase
    if (it.dest == 5'd0) writes = 1'b0;
    if (writes) regs[it.dest] = res;
    r.wrote_reg = writes;
    r.dest_reg = writes ? it.dest : 5'd0;
    r.write_value = writes ? res : 32'd0;
    r.mem_address = is_mem ? addr : 32'd0;
    return r;
  endfunction

  function automatic in_item_t mk(logic [4:0] op, logic [4:0] s1, logic [4:0] s2,
                                  logic [4:0] d, logic [31:0] imm, logic [31:0] pc);
    in_item_t it;
    it.action = op; it.src_one = s1; it.src_two = s2; it.dest = d;
    it.immediate = imm; it.pc_value = pc;
    return it;
  endfunction

  // random instruction, biased toward small registers and in-range addresses
  function automatic in_item_t rand_insn();
    in_item_t    it;
    logic [31:0] imm;
    it = mk(5'($urandom_range(0, 31)), 5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)),
            5'($urandom_range(0, 7)), $urandom, $urandom);
    if ($urandom_range(0, 3) == 0) begin
      it.src_one = 5'($urandom); it.src_two = 5'($urandom); it.dest = 5'($urandom);
    end
    if (it.action > OP_AUIPC && $urandom_range(0, 2) != 0)
      it.action = 5'($urandom_range(0, 28));
    if (it.action >= OP_LB && it.action <= OP_SW) begin
      case ($urandom_range(0, 3))
        0, 1: imm = $urandom_range(0, 63);
        2: imm = $urandom_range(0, DataBytes + 8) - 8;
        default: imm = $urandom;
      endcase
      it.immediate = imm;
      if ($urandom_range(0, 2) != 0) it.src_one = 5'd0;
    end
    return it;
  endfunction

  // stimulus
  initial begin
    foreach (regs[i]) regs[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    // directed part
    pending_insns.push_back(mk(OP_ADDI, 0, 0, 1, 32'h7fffffff, 0));
    pending_insns.push_back(mk(OP_ADDI, 0, 0, 2, 32'h80000000, 0));
    pending_insns.push_back(mk(OP_ADDI, 0, 0, 0, 32'hffffffff, 0));
    pending_insns.push_back(mk(OP_SLTI, 2, 0, 3, 32'd0, 0));
    pending_insns.push_back(mk(OP_SLTIU, 0, 0, 4, 32'hffffffff, 0));
    pending_insns.push_back(mk(OP_SLT, 0, 2, 5, 0, 0));
    pending_insns.push_back(mk(OP_SLTU, 0, 0, 6, 0, 0));
    pending_insns.push_back(mk(OP_ANDI, 1, 0, 7, 32'hf0f0f0f0, 0));
    pending_insns.push_back(mk(OP_ORI, 2, 0, 8, 32'h0000ffff, 0));
    pending_insns.push_back(mk(OP_XORI, 1, 0, 9, 32'hffffffff, 0));
    pending_insns.push_back(mk(OP_SLLI, 1, 0, 10, 32'hffffffff, 0));
    pending_insns.push_back(mk(OP_SRLI, 2, 0, 11, 32'd63, 0));
    pending_insns.push_back(mk(OP_SRAI, 2, 0, 12, 32'd31, 0));
    pending_insns.push_back(mk(OP_ADD, 1, 2, 13, 0, 0));
    pending_insns.push_back(mk(OP_SUB, 2, 1, 14, 0, 0));
    pending_insns.push_back(mk(OP_AND, 1, 2, 15, 0, 0));
    pending_insns.push_back(mk(OP_OR, 1, 2, 16, 0, 0));
    pending_insns.push_back(mk(OP_XOR, 1, 2, 17, 0, 0));
    pending_insns.push_back(mk(OP_SLL, 1, 9, 18, 0, 0));
    pending_insns.push_back(mk(OP_SRL, 2, 1, 19, 0, 0));
    pending_insns.push_back(mk(OP_SRA, 2, 4, 20, 0, 0));
    pending_insns.push_back(mk(OP_SW, 0, 2, 0, DataBytes - 2, 0));
    pending_insns.push_back(mk(OP_LB, 0, 0, 21, DataBytes - 1, 0));
    pending_insns.push_back(mk(OP_LH, 0, 0, 22, 32'hffffffff, 0));
    pending_insns.push_back(mk(OP_LW, 0, 0, 23, DataBytes - 2, 0));
    pending_insns.push_back(mk(OP_SH, 1, 1, 0, 32'd1, 0));
    pending_insns.push_back(mk(OP_SB, 0, 2, 0, 32'd3, 0));
    pending_insns.push_back(mk(OP_LBU, 0, 0, 24, 32'd3, 0));
    pending_insns.push_back(mk(OP_LHU, 0, 0, 25, 32'd1, 0));
    pending_insns.push_back(mk(OP_LUI, 0, 0, 26, 32'hfffff, 0));
    pending_insns.push_back(mk(OP_AUIPC, 0, 0, 27, 32'hfffff, 32'hffffffff));
    pending_insns.push_back(mk(5'd31, 31, 31, 31, 32'hffffffff, 32'hffffffff));
    // random part
    for (int n = 0; n < 1900; n++) pending_insns.push_back(rand_insn());
  end

  // reset, then quiet stretch toggling
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3000) @(posedge clk_i);
    quiet_phase <= 1'b1;
    repeat (1500) @(posedge clk_i);
    quiet_phase <= 1'b0;
  end

  // driver: the head of the queue is the transaction on the bus until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        void'(pending_insns.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_insns.size() > 0 &&
            (quiet_phase || $urandom_range(0, 99) >= 11)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_insns[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (pending_insns.size() == 0 && !in_valid_i) stim_done <= 1'b1;
      out_ready_i <= quiet_phase || ($urandom_range(0, 99) >= 11);
    end
  end

  // predict on accept
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      expected_results.push_back(execute_insn(in_data_i));
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.wrote_reg !== out_data_o.wrote_reg)
          $display("%0t: wrote_reg exp %0h got %0h", $time, exp_r.wrote_reg,
                   out_data_o.wrote_reg);
        if (exp_r.dest_reg !== out_data_o.dest_reg)
          $display("%0t: dest_reg exp %0h got %0h", $time, exp_r.dest_reg,
                   out_data_o.dest_reg);
        if (exp_r.write_value !== out_data_o.write_value)
          $display("%0t: write_value exp %0h got %0h", $time, exp_r.write_value,
                   out_data_o.write_value);
        if (exp_r.mem_address !== out_data_o.mem_address)
          $display("%0t: mem_address exp %0h got %0h", $time, exp_r.mem_address,
                   out_data_o.mem_address);
        if (exp_r.is_store !== out_data_o.is_store)
          $display("%0t: is_store exp %0h got %0h", $time, exp_r.is_store,
                   out_data_o.is_store);
        if (exp_r.addr_out_of_range !== out_data_o.addr_out_of_range)
          $display("%0t: addr_out_of_range exp %0h got %0h", $time,
                   exp_r.addr_out_of_range, out_data_o.addr_out_of_range);
        if (exp_r !== out_data_o) errors++;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("rv32i_integer_execute_unit_test: errors");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done && expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("rv32i_integer_execute_unit_test: clean");
    end else begin
      $display("rv32i_integer_execute_unit_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rv32x_pkg.sv
rtl/core/rv32x_datapath.sv
rtl/core/rv32x_ctrl.sv
rtl/core/rv32i_integer_execute_unit.sv
dv/rv32i_integer_execute_unit_test.sv
